// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define MBS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define MBS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/mbs_pkg.sv =====
package mbs_pkg;

    localparam int MAX_TOKEN  = 64;
    localparam int WIN_DEPTH  = MAX_TOKEN + 8;
    localparam int LEN_W      = $clog2(MAX_TOKEN + 1);
    localparam int FILL_W     = $clog2(WIN_DEPTH + 1);
    localparam int MAX_RES    = 4;
    localparam int RES_CNT_W  = $clog2(MAX_RES + 1);
    localparam int RES_POS_W  = $clog2(MAX_RES);

    localparam int VALUE_W    = 8;
    localparam int TOK_IDX_W  = 6;
    localparam int IN_DATA_W  = 16;
    localparam int CMD_W      = 2;
    localparam int KIND_W     = 2;
    localparam int CFG_LEN_W  = 7;
    localparam int APB_DATA_W = 32;
    localparam int ADDR_W     = 3;
    localparam int REG_IDX_W  = 1;

    localparam logic [REG_IDX_W-1:0] REG_TOKEN_LENGTH = 1'b0;

    localparam logic [VALUE_W-1:0] CH_CR   = 8'd13;
    localparam logic [VALUE_W-1:0] CH_LF   = 8'd10;
    localparam logic [VALUE_W-1:0] CH_DASH = 8'd45;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD = 2'd0,
        CMD_BODY = 2'd1,
        CMD_END  = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef enum logic [KIND_W-1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_DONE = 2'd2,
        KIND_BAD  = 2'd3
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [VALUE_W-1:0]  data;
    } t_result;

    typedef struct packed {
        logic [FILL_W-1:0] fill;
        logic              part_open;
        logic              final_seen;
        logic              fault;
    } t_ctrl;

    typedef logic [WIN_DEPTH-1:0][VALUE_W-1:0] t_window;
    typedef logic [MAX_TOKEN-1:0][VALUE_W-1:0] t_tokens;

endpackage

// ===== rtl/mbs_step.sv =====
// Next-state and result logic for one body item or end-of-body item.
// Window entry 0 is the oldest byte; the newest byte sits at fill - 1.
module mbs_step
    import mbs_pkg::*;
(
    input  t_cmd                   i_cmd,
    input  logic [VALUE_W-1:0]     i_value,
    input  logic [LEN_W-1:0]       i_len,
    input  t_ctrl                  i_ctrl,
    input  t_window                i_window,
    input  t_tokens                i_tokens,
    output t_ctrl                  o_ctrl,
    output t_window                o_window,
    output t_result [MAX_RES-1:0]  o_res,
    output logic [RES_CNT_W-1:0]   o_count
);

    // A plain delimiter can end with zero, one or two bytes in front of it.
    localparam int N_ALIGN = 3;

    logic [FILL_W-1:0]      cap;
    logic [FILL_W-1:0]      fill_c;
    logic [FILL_W-1:0]      fill_q;
    logic                   is_body;
    logic                   is_end;
    logic                   push;
    logic                   full;
    logic                   pop_old;
    t_window                shifted;
    t_window                win_q;
    logic [N_ALIGN-1:0]     head_ok;
    logic [N_ALIGN-1:0]     tok_ok;
    logic [N_ALIGN-1:0]     tail_ok;
    logic [N_ALIGN-1:0]     plain_hit;
    logic                   close_tail_ok;
    logic                   close_hit;
    logic                   hit;
    logic                   po;
    logic                   bad;
    t_result [MAX_RES-1:0]  cand;
    logic [MAX_RES-1:0]     cand_v;
    logic [RES_CNT_W-1:0]   cnt;

    always_comb begin
        cap     = FILL_W'(i_len) + FILL_W'(8);
        fill_c  = (i_ctrl.fill > cap) ? cap : i_ctrl.fill;
        is_body = (i_cmd == CMD_BODY);
        is_end  = (i_cmd == CMD_END);
        push    = is_body && !i_ctrl.fault && !i_ctrl.final_seen;
        full    = (fill_c == cap);
        pop_old = push && full;
    end

    assign shifted = {i_window[WIN_DEPTH-1], i_window[WIN_DEPTH-1:1]};

    // Window after the new byte is taken in, with the oldest byte dropped when full.
    always_comb begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            if (!push) begin
                win_q[i] = i_window[i];
            end else if (full) begin
                win_q[i] = (i == int'(cap) - 1) ? i_value : shifted[i];
            end else begin
                win_q[i] = (i == int'(fill_c)) ? i_value : i_window[i];
            end
        end
        if (!push) begin
            fill_q = fill_c;
        end else if (full) begin
            fill_q = cap;
        end else begin
            fill_q = fill_c + FILL_W'(1);
        end
    end

    // Delimiter compare at every alignment that the fill level allows.
    always_comb begin
        for (int b = 0; b < N_ALIGN; b++) begin
            head_ok[b] = (win_q[b] == CH_CR) && (win_q[b+1] == CH_LF) &&
                         (win_q[b+2] == CH_DASH) && (win_q[b+3] == CH_DASH);
            tok_ok[b]  = 1'b1;
            for (int k = 0; k < MAX_TOKEN; k++) begin
                if (k < int'(i_len) && win_q[b+4+k] != i_tokens[k]) begin
                    tok_ok[b] = 1'b0;
                end
            end
            tail_ok[b] = 1'b1;
            for (int i = 0; i < WIN_DEPTH; i++) begin
                if (i == b + 4 + int'(i_len) && win_q[i] != CH_CR) begin
                    tail_ok[b] = 1'b0;
                end
                if (i == b + 5 + int'(i_len) && win_q[i] != CH_LF) begin
                    tail_ok[b] = 1'b0;
                end
            end
            plain_hit[b] = push && (int'(fill_q) == int'(i_len) + 6 + b) &&
                           head_ok[b] && tok_ok[b] && tail_ok[b];
        end

        close_tail_ok = 1'b1;
        for (int i = 0; i < WIN_DEPTH; i++) begin
            if ((i == 4 + int'(i_len) || i == 5 + int'(i_len)) && win_q[i] != CH_DASH) begin
                close_tail_ok = 1'b0;
            end
            if (i == 6 + int'(i_len) && win_q[i] != CH_CR) begin
                close_tail_ok = 1'b0;
            end
            if (i == 7 + int'(i_len) && win_q[i] != CH_LF) begin
                close_tail_ok = 1'b0;
            end
        end
        close_hit = (fill_q == cap) && head_ok[0] && tok_ok[0] && close_tail_ok;
        hit       = |plain_hit;
    end

    always_comb begin
        cand   = '0;
        cand_v = '0;
        o_ctrl = i_ctrl;
        po     = i_ctrl.part_open;
        bad    = 1'b0;
        if (push) begin
            po        = i_ctrl.part_open | pop_old | plain_hit[1] | plain_hit[2];
            cand[0]   = '{kind: KIND_DATA, data: i_window[0]};
            cand_v[0] = pop_old;
            cand[1]   = '{kind: KIND_DATA, data: win_q[0]};
            cand_v[1] = plain_hit[1] | plain_hit[2];
            cand[2]   = '{kind: KIND_DATA, data: win_q[1]};
            cand_v[2] = plain_hit[2];
            cand[3]   = '{kind: KIND_END, data: '0};
            cand_v[3] = hit && po;
            o_ctrl.fill       = hit ? '0 : fill_q;
            o_ctrl.part_open  = po && !hit;
            o_ctrl.final_seen = !hit && close_hit;
        end else if (is_body) begin
            // Data after the closing delimiter is dropped.
            o_ctrl.fault = 1'b1;
        end else if (is_end) begin
            bad       = i_ctrl.fault || (fill_c != cap) || !close_hit;
            cand[0]   = '{kind: KIND_BAD, data: '0};
            cand_v[0] = bad;
            cand[1]   = '{kind: KIND_END, data: '0};
            cand_v[1] = !bad && i_ctrl.part_open;
            cand[2]   = '{kind: KIND_DONE, data: '0};
            cand_v[2] = !bad;
            o_ctrl    = '0;
        end
    end

    // Pack the valid candidates to the front of the result list.
    always_comb begin
        o_res = '0;
        cnt   = '0;
        for (int s = 0; s < MAX_RES; s++) begin
            if (cand_v[s]) begin
                o_res[cnt[RES_POS_W-1:0]] = cand[s];
                cnt = cnt + RES_CNT_W'(1);
            end
        end
    end

    assign o_count  = cnt;
    assign o_window = win_q;

endmodule

// ===== rtl/multipart_boundary_splitter_unit.sv =====
// Multipart body splitter. Each input transfer carries a command in tuser: load one
// boundary token character (value, token_index in tdata), one body byte, or end of
// body. Body bytes pass through a delay window of token_length + 8 bytes that is
// compared in parallel against the delimiter CR LF "--" token CR LF and the closing
// delimiter CR LF "--" token "--" CR LF. Part bytes leave in order as kind 0, a part
// end as kind 1, end of body as kind 2 (done) or kind 3 (bad final block); tlast
// marks the last result caused by one input item. The block takes one input transfer
// per cycle while the result register is empty or giving out its last entry; else the
// item waits in the input register. Its whole result list (up to four entries) is
// built in a single pass and loaded into the result register, which drains one
// transfer per cycle while the receiver is ready. A steady body stream gives one byte
// in and at most one byte out per cycle while the receiver is ready and no byte gives
// more than one result. Token characters and token_length must be set before the body
// they apply to; writing token_length empties the window and must only be done while
// the block is idle; the block itself does not check this.
`include "assert_macros.svh"

module multipart_boundary_splitter_unit
    import mbs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [7:0] value, [13:8] token_index, [15:14] zero
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    // [1:0] command
    input  logic [CMD_W-1:0]       s_axis_tuser,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] data_out
    output logic [VALUE_W-1:0]     m_axis_tdata,
    // [1:0] kind
    output logic [KIND_W-1:0]      m_axis_tuser,
    output logic                   m_axis_tlast,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    // Input register.
    logic                   r_in_valid;
    t_cmd                   r_in_cmd;
    logic [VALUE_W-1:0]     r_in_value;
    logic [TOK_IDX_W-1:0]   r_in_idx;

    // Block state.
    logic [CFG_LEN_W-1:0]   r_len;
    t_ctrl                  r_ctrl;
    t_window                r_window;
    t_tokens                r_tokens;

    // Result register: a short list drained one transfer at a time.
    t_result [MAX_RES-1:0]  r_res;
    logic [RES_CNT_W-1:0]   r_rem;
    logic [RES_POS_W-1:0]   r_pos;

    logic [LEN_W-1:0]       eff_len;
    logic [FILL_W-1:0]      cap;
    logic                   out_xfer;
    logic                   bundle_free;
    logic                   proc;
    logic                   cfg_wr;

    t_ctrl                  n_ctrl;
    t_window                n_window;
    t_result [MAX_RES-1:0]  n_res;
    logic [RES_CNT_W-1:0]   n_count;

    // A token length of zero counts as one, and anything past the store as its size.
    always_comb begin
        if (r_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (int'(r_len) > MAX_TOKEN) begin
            eff_len = LEN_W'(MAX_TOKEN);
        end else begin
            eff_len = LEN_W'(r_len);
        end
        cap = FILL_W'(eff_len) + FILL_W'(8);
    end

    assign out_xfer      = m_axis_tvalid && m_axis_tready;
    assign bundle_free   = (r_rem == '0) || (r_rem == RES_CNT_W'(1) && out_xfer);
    assign proc          = r_in_valid && bundle_free;
    assign s_axis_tready = !r_in_valid || proc;

    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[ADDR_W-1 -: REG_IDX_W] == REG_TOKEN_LENGTH);

    mbs_step u_step (
        .i_cmd    (r_in_cmd),
        .i_value  (r_in_value),
        .i_len    (eff_len),
        .i_ctrl   (r_ctrl),
        .i_window (r_window),
        .i_tokens (r_tokens),
        .o_ctrl   (n_ctrl),
        .o_window (n_window),
        .o_res    (n_res),
        .o_count  (n_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_len      <= CFG_LEN_W'(1);
            r_ctrl     <= '0;
            r_rem      <= '0;
            r_pos      <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (proc) begin
                r_ctrl <= n_ctrl;
            end
            // A new token length empties the window; part and final flags stay.
            if (cfg_wr) begin
                r_len       <= pwdata[CFG_LEN_W-1:0];
                r_ctrl.fill <= '0;
            end
            if (proc && n_count != '0) begin
                r_rem <= n_count;
                r_pos <= '0;
            end else if (out_xfer) begin
                r_rem <= r_rem - RES_CNT_W'(1);
                r_pos <= r_pos + RES_POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd   <= t_cmd'(s_axis_tuser);
            r_in_value <= s_axis_tdata[VALUE_W-1:0];
            r_in_idx   <= s_axis_tdata[VALUE_W +: TOK_IDX_W];
        end
        if (proc) begin
            r_window <= n_window;
        end
        if (proc && r_in_cmd == CMD_LOAD && int'(r_in_idx) < MAX_TOKEN) begin
            r_tokens[r_in_idx] <= r_in_value;
        end
        if (proc && n_count != '0) begin
            r_res <= n_res;
        end
    end

    assign m_axis_tvalid = (r_rem != '0);
    assign m_axis_tdata  = r_res[r_pos].data;
    assign m_axis_tuser  = r_res[r_pos].kind;
    assign m_axis_tlast  = (r_rem == RES_CNT_W'(1));

    assign pready = 1'b1;

    always_comb begin
        if (paddr[ADDR_W-1 -: REG_IDX_W] == REG_TOKEN_LENGTH) begin
            prdata = {{(APB_DATA_W - CFG_LEN_W){1'b0}}, r_len};
        end else begin
            prdata = '0;
        end
    end

    // The window never holds more than the closing delimiter.
    `MBS_ASSERT(a_fill_cap, i_clk, i_rst_n, r_ctrl.fill <= cap, "window fill beyond capacity")

    // The drain position never runs past the end of the result list.
    `MBS_ASSERT(a_res_span, i_clk, i_rst_n, (RES_CNT_W'(r_pos) + r_rem) <= RES_CNT_W'(MAX_RES), "result list overrun")

    // Body data after the closing delimiter marks the body as faulty.
    `MBS_ASSERT_NEXT(a_late_fault, i_clk, i_rst_n, proc && r_in_cmd == CMD_BODY && r_ctrl.final_seen, r_ctrl.fault, "late data did not set fault")

    // End of body leaves the stream state clean for the next body.
    `MBS_ASSERT_NEXT(a_end_clear, i_clk, i_rst_n, proc && r_in_cmd == CMD_END, r_ctrl == '0, "stream state not cleared at end of body")

endmodule

// ===== dv/multipart_boundary_splitter_unit_test.sv =====
module multipart_boundary_splitter_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mbs_pkg::*;

    // Run length and pacing. The cycle limit is far above the slowest legal run:
    // well under a thousand input transfers, each with up to four results waiting out
    // a half-idle receiver, plus one long receiver stall.
    localparam int CYCLE_LIMIT       = 200000;
    localparam int LONG_STALL        = 400;
    localparam int DRAIN_CYCLES      = 8;
    localparam int ITEMS_PER_SETTING = 24;

    // One input item as the splitter sees it, and one result as it leaves.
    typedef struct {
        t_cmd                 cmd;
        logic [VALUE_W-1:0]   value;
        logic [TOK_IDX_W-1:0] tok_idx;
    } t_body_cmd;

    typedef struct {
        t_kind              kind;
        logic [VALUE_W-1:0] data;
        logic               last;
    } t_split_out;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic [CMD_W-1:0]       s_axis_tuser = '0;

    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [VALUE_W-1:0]     m_axis_tdata;
    logic [KIND_W-1:0]      m_axis_tuser;
    logic                   m_axis_tlast;

    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [ADDR_W-1:0]      paddr = '0;
    logic [APB_DATA_W-1:0]  pwdata = '0;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    // Items waiting to be offered, and results predicted but not yet seen.
    t_body_cmd   body_cmd_q[$];
    t_split_out  split_results_q[$];
    t_body_cmd   on_bus;

    // Pacing knobs; all but the long stall request change only while the block is idle.
    int unsigned send_idle_pct = 25;
    int unsigned recv_idle_pct = 49;
    bit          long_stall_req = 1'b0;
    bit          long_stall_done = 1'b0;
    int unsigned stall_left = 0;

    int unsigned mismatch_count = 0;
    int unsigned results_seen = 0;
    int unsigned cycle_count = 0;

    // Stimulus bookkeeping: the token the stimulus has loaded and the length in use.
    t_tokens     token_plan = '0;
    int unsigned cur_len = 1;
    int unsigned stim_count = 0;

    // Predictor state: its own copy of the token, the delay window and the flags.
    t_tokens              tok_chars;
    logic [VALUE_W-1:0]   win_bytes [WIN_DEPTH];
    int unsigned          win_fill;
    bit                   part_held;
    bit                   closing_seen;
    bit                   late_fault;
    logic [CFG_LEN_W-1:0] tok_len_reg;

    multipart_boundary_splitter_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void splitter_reset();
        tok_chars    = '0;
        win_fill     = 0;
        part_held    = 1'b0;
        closing_seen = 1'b0;
        late_fault   = 1'b0;
        tok_len_reg  = 7'd1;
    endfunction

    // A length of zero acts as one, anything above the token store as its full size.
    function automatic int unsigned live_len(input logic [CFG_LEN_W-1:0] len);
        if (len == 0) return 1;
        if (len > MAX_TOKEN) return MAX_TOKEN;
        return len;
    endfunction

    // Byte k of the delimiter CR LF "--" token CR LF, or of the closing form that has
    // "--" between the token and the final CR LF.
    function automatic logic [VALUE_W-1:0] delim_byte(input int unsigned k,
                                                      input int unsigned len,
                                                      input bit closing,
                                                      input t_tokens toks);
        if (k == 0) return CH_CR;
        if (k == 1) return CH_LF;
        if (k < 4) return CH_DASH;
        k -= 4;
        if (k < len) return toks[k];
        k -= len;
        if (closing) begin
            if (k < 2) return CH_DASH;
            if (k == 2) return CH_CR;
            if (k == 3) return CH_LF;
            return '0;
        end
        if (k == 0) return CH_CR;
        if (k == 1) return CH_LF;
        return '0;
    endfunction

    function automatic bit window_tail_is(input int unsigned dlen, input int unsigned len,
                                          input bit closing);
        int unsigned base;
        if (win_fill < dlen) return 1'b0;
        base = win_fill - dlen;
        for (int unsigned i = 0; i < dlen; i++) begin
            if (win_bytes[base + i] != delim_byte(i, len, closing, tok_chars)) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Works out the results of one accepted item and queues them in order.
    function automatic void predict_split(input t_body_cmd c);
        t_split_out  outs[$];
        int unsigned len;
        int unsigned cap;
        int unsigned pre;
        len = live_len(tok_len_reg);
        cap = len + 8;
        case (c.cmd)
            CMD_LOAD: tok_chars[c.tok_idx] = c.value;
            CMD_BODY: begin
                if (late_fault || closing_seen) begin
                    // Anything after the closing delimiter is swallowed and poisons the body.
                    late_fault = 1'b1;
                end else begin
                    if (win_fill > cap) win_fill = cap;
                    if (win_fill == cap) begin
                        outs.push_back(t_split_out'{KIND_DATA, win_bytes[0], 1'b0});
                        part_held = 1'b1;
                        for (int unsigned i = 0; i + 1 < win_fill; i++)
                            win_bytes[i] = win_bytes[i + 1];
                        win_fill--;
                    end
                    win_bytes[win_fill] = c.value;
                    win_fill++;
                    if (window_tail_is(len + 6, len, 1'b0)) begin
                        pre = win_fill - (len + 6);
                        for (int unsigned i = 0; i < pre; i++) begin
                            outs.push_back(t_split_out'{KIND_DATA, win_bytes[i], 1'b0});
                            part_held = 1'b1;
                        end
                        if (part_held) begin
                            outs.push_back(t_split_out'{KIND_END, '0, 1'b0});
                            part_held = 1'b0;
                        end
                        win_fill = 0;
                    end else if (win_fill == cap && window_tail_is(cap, len, 1'b1)) begin
                        closing_seen = 1'b1;
                    end
                end
            end
            CMD_END: begin
                if (late_fault || win_fill != cap || !window_tail_is(cap, len, 1'b1)) begin
                    outs.push_back(t_split_out'{KIND_BAD, '0, 1'b0});
                end else begin
                    if (part_held) outs.push_back(t_split_out'{KIND_END, '0, 1'b0});
                    outs.push_back(t_split_out'{KIND_DONE, '0, 1'b0});
                end
                win_fill     = 0;
                part_held    = 1'b0;
                closing_seen = 1'b0;
                late_fault   = 1'b0;
            end
            default: ;
        endcase
        if (outs.size() != 0) outs[outs.size() - 1].last = 1'b1;
        foreach (outs[i]) split_results_q.push_back(outs[i]);
    endfunction

    // ------------------------------------------------------------------
    // Input driver: offers queued items, predicts each one on its transfer.
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_split(on_bus);
            // A new item may go on the bus only once the previous one has transferred.
            if (!s_axis_tvalid || s_axis_tready) begin
                if (body_cmd_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    on_bus = body_cmd_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {2'b00, on_bus.tok_idx, on_bus.value};
                    s_axis_tuser  <= on_bus.cmd;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver readiness. The long stall is counted here so that the sender keeps
    // offering items while the block backs up behind a blocked output.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (long_stall_req && !long_stall_done) begin
            stall_left = LONG_STALL;
            long_stall_done = 1'b1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Output monitor: every result transfer is checked against the oldest prediction.
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("ERROR at %0t: %s", $realtime, msg);
    endtask

    always @(posedge i_clk) begin
        t_split_out want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (split_results_q.size() == 0) begin
                report_mismatch($sformatf("result %0d (kind %0d data %02h) not expected",
                                          results_seen, m_axis_tuser, m_axis_tdata));
            end else begin
                want = split_results_q.pop_front();
                if (m_axis_tuser != want.kind)
                    report_mismatch($sformatf("result %0d kind %0d, expected %0d",
                                              results_seen, m_axis_tuser, want.kind));
                if (m_axis_tdata != want.data)
                    report_mismatch($sformatf("result %0d data %02h, expected %02h",
                                              results_seen, m_axis_tdata, want.data));
                if (m_axis_tlast != want.last)
                    report_mismatch($sformatf("result %0d last %0d, expected %0d",
                                              results_seen, m_axis_tlast, want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Any non-load item carries random index bits beside the caller's value.
    task automatic add_item(input t_cmd cmd, input logic [VALUE_W-1:0] value);
        body_cmd_q.push_back(t_body_cmd'{cmd, value, TOK_IDX_W'($urandom_range(63, 0))});
        if (cmd != CMD_NONE) stim_count++;
    endtask

    task automatic add_load(input int unsigned idx, input logic [VALUE_W-1:0] value);
        body_cmd_q.push_back(t_body_cmd'{CMD_LOAD, value, TOK_IDX_W'(idx)});
        stim_count++;
    endtask

    // Sends the first count bytes of a delimiter; a short count gives a near miss.
    task automatic add_delim_bytes(input bit closing, input int unsigned count);
        for (int unsigned k = 0; k < count; k++)
            add_item(CMD_BODY, delim_byte(k, cur_len, closing, token_plan));
    endtask

    // One body: a few parts of random bytes with an occasional partial delimiter
    // inside, each closed by a delimiter, then mostly a clean closing delimiter and
    // end of body. The rest ends badly: junk after the close, no close at all, a
    // second close, or a close cut short. Long tokens get fewer parts, since each
    // delimiter is already long.
    task automatic add_body();
        int unsigned parts;
        int unsigned n;
        int unsigned pick;
        parts = (cur_len > 16) ? $urandom_range(1, 0) : $urandom_range(3, 0);
        repeat (parts) begin
            n = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 0);
            repeat (n) begin
                pick = $urandom_range(29, 0);
                if (pick < 3) add_delim_bytes(1'b0, $urandom_range(cur_len + 5, 1));
                else if (pick == 3) add_item(CMD_NONE, VALUE_W'($urandom_range(255, 0)));
                else add_item(CMD_BODY, VALUE_W'($urandom_range(255, 0)));
            end
            add_delim_bytes(1'b0, cur_len + 6);
        end
        pick = $urandom_range(9, 0);
        if (pick <= 5) begin
            add_delim_bytes(1'b1, cur_len + 8);
        end else if (pick == 6) begin
            add_delim_bytes(1'b1, cur_len + 8);
            repeat ($urandom_range(3, 1))
                add_item(CMD_BODY, VALUE_W'($urandom_range(255, 0)));
        end else if (pick == 8) begin
            add_delim_bytes(1'b1, cur_len + 8);
            add_delim_bytes(1'b1, cur_len + 8);
        end else if (pick == 9) begin
            add_delim_bytes(1'b1, $urandom_range(cur_len + 7, 1));
        end
        add_item(CMD_END, VALUE_W'($urandom_range(255, 0)));
    endtask

    // Waits until nothing is queued, on the bus or predicted, then lets the block's
    // pipeline settle so that an item without results has left it too.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (body_cmd_q.size() != 0 || s_axis_tvalid || split_results_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // Register write: setup cycle, then access cycle; the write lands at the edge
    // that ends the access cycle, and the predictor follows at that same edge.
    task automatic write_token_length(input logic [CFG_LEN_W-1:0] len);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_TOKEN_LENGTH, 2'b00};
        pwdata  <= APB_DATA_W'(len);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tok_len_reg = len;
        win_fill = 0;
        cur_len = live_len(len);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial begin
        logic [CFG_LEN_W-1:0] len_plan [6];
        int unsigned          target;
        int unsigned          pos;

        splitter_reset();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset token length of one, token "A". Both ends of the
        // token index are loaded, the second with byte FF, and an unknown command is sent.
        token_plan[0] = 8'h41;
        add_load(0, 8'h41);
        add_load(63, 8'hFF);
        add_item(CMD_NONE, 8'h55);
        // A delimiter right at the start closes an empty part: no part end.
        add_delim_bytes(1'b0, cur_len + 6);
        // Two extreme bytes, then the closing delimiter pushes them out of the window;
        // end of body gives the part end followed by done.
        add_item(CMD_BODY, 8'h00);
        add_item(CMD_BODY, 8'hFF);
        add_delim_bytes(1'b1, cur_len + 8);
        add_item(CMD_END, 8'h00);
        // A body that is not the closing delimiter ends as an invalid final block.
        add_item(CMD_BODY, 8'h42);
        add_item(CMD_END, 8'hFF);
        wait_drained();

        // Random part: six token length settings, both extremes and both out-of-range
        // values among them, over three pacing modes.
        len_plan[0] = 7'd64;
        len_plan[1] = 7'd0;
        len_plan[2] = CFG_LEN_W'($urandom_range(8, 2));
        len_plan[3] = 7'd127;
        len_plan[4] = CFG_LEN_W'($urandom_range(63, 9));
        len_plan[5] = 7'd1;

        for (int k = 0; k < 6; k++) begin
            // Every other change is made after three to twenty body bytes, so that the write
            // empties the window but keeps any part that they opened.
            if (k % 2 == 1) begin
                repeat ($urandom_range(20, 3))
                    add_item(CMD_BODY, VALUE_W'($urandom_range(255, 0)));
                wait_drained();
            end
            case (k / 2)
                0: begin send_idle_pct = 25; recv_idle_pct = 49; end
                1: begin send_idle_pct = 49; recv_idle_pct = 25; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            write_token_length(len_plan[k]);
            for (int unsigned i = 0; i < cur_len; i++) begin
                token_plan[i] = VALUE_W'($urandom_range(255, 0));
                add_load(i, token_plan[i]);
            end
            target = stim_count + ITEMS_PER_SETTING;
            while (stim_count < target) begin
                // Now and then one token character changes between bodies.
                if ($urandom_range(5, 0) == 0) begin
                    pos = $urandom_range(cur_len - 1, 0);
                    token_plan[pos] = VALUE_W'($urandom_range(255, 0));
                    add_load(pos, token_plan[pos]);
                end
                add_body();
            end
            if (k == 2) begin
                @(negedge i_clk);
                long_stall_req = 1'b1;
            end
            wait_drained();
        end

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
